@@ rtl/lba_chs_converter_macros.svh @@
// assertion macros used by lcc_stage
`ifndef LBA_CHS_CONVERTER_MACROS_SVH
`define LBA_CHS_CONVERTER_MACROS_SVH
`ifndef NO_ASSERTIONS
// consequent checked in the same cycle
`define LCC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lba_chs_converter assertion failed");
// consequent checked in the next cycle
`define LCC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lba_chs_converter assertion failed");
`else
`define LCC_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define LCC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/lcc_pkg.sv @@
package lcc_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_GEOM  = 2'd2
  } status_t;

  // register indexes (byte address bits 3:2)
  localparam logic [1:0] REG_HPC  = 2'd0;
  localparam logic [1:0] REG_SPT  = 2'd1;
  localparam logic [1:0] REG_MODE = 2'd2;

  // address width modes
  localparam logic [1:0] MODE_22 = 2'd0;
  localparam logic [1:0] MODE_28 = 2'd1;

  // reset geometry
  localparam logic [7:0] HPC_RESET  = 8'd16;
  localparam logic [5:0] SPT_RESET  = 6'd63;
  localparam logic [1:0] MODE_RESET = 2'd2;

  // divider layout
  localparam int AW        = 48;
  localparam int PW        = 62;
  localparam int DIV_STEPS = 4;
  localparam int DIV_STAGES = AW / DIV_STEPS;
  localparam int NSTAGE    = 2 * DIV_STAGES;

  typedef struct packed {
    logic [7:0] hpc;
    logic [5:0] spt;
    logic [1:0] mode;
  } cfg_t;

  // one word in flight
  typedef struct packed {
    logic          cmd;
    status_t       status;
    cfg_t          cfg;
    logic [AW-1:0] quo;
    logic [7:0]    rem;
    logic [5:0]    r1;
    logic [PW-1:0] prod;
    logic [7:0]    hd;
    logic [5:0]    sec;
  } item_t;

  // address not below the selected limit
  function automatic logic over_limit(input logic [PW-1:0] v, input logic [1:0] mode);
    logic r;
    r = |v[PW-1:AW];
    if (mode == MODE_22) begin
      r = |v[PW-1:22];
    end else if (mode == MODE_28) begin
      r = |v[PW-1:28];
    end
    return r;
  endfunction

endpackage

@@ rtl/lcc_cfg.sv @@
module lcc_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output lcc_pkg::cfg_t     cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  // geometry registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hpc  <= lcc_pkg::HPC_RESET;
      cfg.spt  <= lcc_pkg::SPT_RESET;
      cfg.mode <= lcc_pkg::MODE_RESET;
    end else if (wr) begin
      case (paddr[3:2])
        lcc_pkg::REG_HPC:  cfg.hpc  <= pwdata[7:0];
        lcc_pkg::REG_SPT:  cfg.spt  <= pwdata[5:0];
        lcc_pkg::REG_MODE: cfg.mode <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr[3:2])
      lcc_pkg::REG_HPC:  prdata = {24'd0, cfg.hpc};
      lcc_pkg::REG_SPT:  prdata = {26'd0, cfg.spt};
      lcc_pkg::REG_MODE: prdata = {30'd0, cfg.mode};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

@@ rtl/lcc_entry.sv @@
module lcc_entry (
  input  logic                 clk,
  input  logic                 rst,
  input  lcc_pkg::cfg_t        cfg,
  input  logic                 in_valid,
  input  logic                 cmd,
  input  logic [47:0]          block_address,
  input  logic [47:0]          cylinder,
  input  logic [7:0]           head,
  input  logic [5:0]           sector,
  input  logic                 dn_ready,
  output logic                 up_ready,
  output logic                 valid,
  output lcc_pkg::item_t       item
);

  lcc_pkg::item_t item_next;

  assign up_ready = !valid || dn_ready;

  // input checks and operand setup
  always_comb begin
    item_next        = '0;
    item_next.cmd    = cmd;
    item_next.cfg    = cfg;
    item_next.hd     = head;
    item_next.sec    = sector;
    item_next.status = lcc_pkg::ST_OK;
    item_next.quo    = block_address;
    item_next.prod   = lcc_pkg::PW'(cylinder);
    if (cfg.hpc == '0 || cfg.spt == '0) begin
      item_next.status = lcc_pkg::ST_GEOM;
    end else if (!cmd) begin
      if (lcc_pkg::over_limit(lcc_pkg::PW'(block_address), cfg.mode)) begin
        item_next.status = lcc_pkg::ST_RANGE;
      end
    end else if (sector == '0 || head >= cfg.hpc) begin
      item_next.status = lcc_pkg::ST_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && in_valid) begin
      item <= item_next;
    end
  end

endmodule

@@ rtl/lcc_stage.sv @@
`include "lba_chs_converter_macros.svh"

module lcc_stage #(
  parameter bit DIV_HPC   = 1'b0,
  parameter bit FIRST_HPC = 1'b0,
  parameter int MSTEP     = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  lcc_pkg::item_t   in_item,
  input  logic             dn_ready,
  output logic             up_ready,
  output logic             valid,
  output lcc_pkg::item_t   item
);

  lcc_pkg::item_t item_next;
  logic [7:0]     divisor;
  logic [8:0]     trial;
  logic [55:0]    mul_a;
  logic           geom_zero;

  assign up_ready = !valid || dn_ready;

  // four restoring division steps plus, where MSTEP selects one, a step of the chs product
  always_comb begin
    item_next = in_item;
    trial     = '0;
    mul_a     = '0;
    if (FIRST_HPC) begin
      item_next.r1  = in_item.rem[5:0];
      item_next.rem = '0;
    end
    divisor = DIV_HPC ? in_item.cfg.hpc : {2'd0, in_item.cfg.spt};
    for (int i = 0; i < lcc_pkg::DIV_STEPS; i++) begin
      trial         = {item_next.rem, item_next.quo[lcc_pkg::AW-1]};
      item_next.quo = {item_next.quo[lcc_pkg::AW-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        item_next.rem    = 8'(trial - {1'b0, divisor});
        item_next.quo[0] = 1'b1;
      end else begin
        item_next.rem = trial[7:0];
      end
    end
    if (MSTEP == 1) begin
      mul_a          = {8'd0, in_item.prod[47:0]} * {48'd0, in_item.cfg.hpc};
      item_next.prod = lcc_pkg::PW'(mul_a) + lcc_pkg::PW'(in_item.hd);
    end else if (MSTEP == 2) begin
      // full-width product, up to 62 bits
      item_next.prod = {6'd0, in_item.prod[55:0]} * {56'd0, in_item.cfg.spt};
    end else if (MSTEP == 3) begin
      item_next.prod = in_item.prod + lcc_pkg::PW'(in_item.sec) - lcc_pkg::PW'(1);
      if (in_item.cmd && in_item.status == lcc_pkg::ST_OK &&
          lcc_pkg::over_limit(item_next.prod, in_item.cfg.mode)) begin
        item_next.status = lcc_pkg::ST_RANGE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && in_valid) begin
      item <= item_next;
    end
  end

  assign geom_zero = item.cfg.hpc == '0 || item.cfg.spt == '0;

  // held word stays in place
  `LCC_ASSERT_NEXT(a_hold_valid, clk, rst, valid && !dn_ready, valid)
  `LCC_ASSERT_NEXT(a_hold_item, clk, rst, valid && !dn_ready, $stable(item))
  // drained stage with nothing arriving goes empty
  `LCC_ASSERT_NEXT(a_drain, clk, rst, dn_ready && !in_valid, !valid)
  // geometry error only travels with a zero geometry value
  `LCC_ASSERT_SAME(a_geom, clk, rst, valid && item.status == lcc_pkg::ST_GEOM, geom_zero)

endmodule

@@ rtl/lba_chs_converter.sv @@
// throughput: one word per cycle while out_stall is low; a 24-stage divider
// (4 quotient bits per stage, by sectors then by heads) sets the depth, the chs
// product rides along
// reset: synchronous, clears all stage valid bits and loads geometry 16/63/48-bit
module lba_chs_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [47:0] block_address,
  input  logic [47:0] cylinder,
  input  logic [7:0]  head,
  input  logic [5:0]  sector,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [47:0] block_address_out,
  output logic [47:0] cylinder_out,
  output logic [7:0]  head_out,
  output logic [5:0]  sector_out,
  output logic [1:0]  status
);

  localparam int NST = lcc_pkg::NSTAGE;

  lcc_pkg::cfg_t  cfg;
  logic           vld [NST+1];
  lcc_pkg::item_t itm [NST+1];
  logic           rdy [NST+2];
  lcc_pkg::item_t last;

  lcc_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  // checks stage
  lcc_entry u_entry (
    .clk(clk), .rst(rst), .cfg(cfg), .in_valid(in_valid), .cmd(cmd),
    .block_address(block_address), .cylinder(cylinder), .head(head),
    .sector(sector), .dn_ready(rdy[1]), .up_ready(rdy[0]),
    .valid(vld[0]), .item(itm[0])
  );

  assign in_stall = !rdy[0];
  assign rdy[NST+1] = !out_stall;

  // divider stages
  for (genvar g = 1; g <= NST; g++) begin : g_stage
    lcc_stage #(
      .DIV_HPC(g > lcc_pkg::DIV_STAGES),
      .FIRST_HPC(g == lcc_pkg::DIV_STAGES + 1),
      .MSTEP(g <= 3 ? g : 0)
    ) u_stage (
      .clk(clk), .rst(rst), .in_valid(vld[g-1]), .in_item(itm[g-1]),
      .dn_ready(rdy[g+1]), .up_ready(rdy[g]), .valid(vld[g]), .item(itm[g])
    );
  end

  // output formatting
  assign last      = itm[NST];
  assign out_valid = vld[NST];

  always_comb begin
    block_address_out = '0;
    cylinder_out      = '0;
    head_out          = '0;
    sector_out        = '0;
    status            = last.status;
    if (last.status == lcc_pkg::ST_OK) begin
      if (last.cmd) begin
        block_address_out = last.prod[47:0];
      end else begin
        cylinder_out = last.quo;
        head_out     = last.rem;
        sector_out   = last.r1 + 6'd1;
      end
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  // expected result word
  typedef struct {
    logic [47:0] lba;
    logic [47:0] cyl;
    logic [7:0]  hd;
    logic [5:0]  sec;
    logic [1:0]  st;
  } chs_word_t;

  // predictor plus queue of pending conversions
  class conv_scoreboard;
    logic [7:0] hpc;
    logic [5:0] spt;
    logic [1:0] mode;
    chs_word_t pending[$];
    int errors;

    function new();
      hpc = lcc_pkg::HPC_RESET; spt = lcc_pkg::SPT_RESET; mode = lcc_pkg::MODE_RESET;
      errors = 0;
    endfunction

    function void note_input(logic c, logic [47:0] a, logic [47:0] cy,
                             logic [7:0] h, logic [5:0] s);
      chs_word_t w;
      logic [63:0] limit, prod;
      w.lba = '0; w.cyl = '0; w.hd = '0; w.sec = '0; w.st = lcc_pkg::ST_OK;
      limit = (mode == lcc_pkg::MODE_22) ? 64'd1 << 22 :
              (mode == lcc_pkg::MODE_28) ? 64'd1 << 28 : 64'd1 << 48;
      if (hpc == 0 || spt == 0) begin
        w.st = lcc_pkg::ST_GEOM;
      end else if (c == 1'b0) begin
        if ({16'd0, a} >= limit) begin
          w.st = lcc_pkg::ST_RANGE;
        end else begin
          w.cyl = 48'({16'd0, a} / (64'(hpc) * 64'(spt)));
          w.hd = 8'(({16'd0, a} / 64'(spt)) % 64'(hpc));
          w.sec = 6'(({16'd0, a} % 64'(spt)) + 64'd1);
        end
      end else if (s == 0 || h >= hpc) begin
        w.st = lcc_pkg::ST_RANGE;
      end else begin
        prod = ({16'd0, cy} * 64'(hpc) + 64'(h)) * 64'(spt) + 64'(s) - 64'd1;
        if (prod >= limit) w.st = lcc_pkg::ST_RANGE;
        else w.lba = prod[47:0];
      end
      pending.push_back(w);
    endfunction

    function void check_result(logic [47:0] l, logic [47:0] cy, logic [7:0] h,
                               logic [5:0] s, logic [1:0] st);
      chs_word_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual lba %h st %0d", $time, l, st);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (l !== w.lba || cy !== w.cyl || h !== w.hd || s !== w.sec || st !== w.st) begin
        $display("%0t: mismatch expected lba %h cyl %h hd %h sec %h st %0d", $time,
                 w.lba, w.cyl, w.hd, w.sec, w.st);
        $display("%0t:          actual   lba %h cyl %h hd %h sec %h st %0d", $time,
                 l, cy, h, s, st);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_stall, cmd;
  logic [47:0] block_address, cylinder;
  logic [7:0] head;
  logic [5:0] sector;
  logic out_valid, out_stall;
  logic [47:0] block_address_out, cylinder_out;
  logic [7:0] head_out;
  logic [5:0] sector_out;
  logic [1:0] status;
  bit calm;
  conv_scoreboard sb;

  lba_chs_converter dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("Test completed with failures");
    $finish;
  end

  // output side: random stall bursts, check each accepted word
  initial begin
    int n;
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        sb.check_result(block_address_out, cylinder_out, head_out, sector_out, status);
      if (n > 0) begin
        n--;
        out_stall <= 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(0, 5);
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      lcc_pkg::REG_HPC:  sb.hpc = val[7:0];
      lcc_pkg::REG_SPT:  sb.spt = val[5:0];
      default:           sb.mode = val[1:0];
    endcase
  endtask

  // send one word, with an optional idle burst before it; valid stays up
  // after acceptance so the next word can follow in the very next cycle
  task automatic send_word(logic c, logic [47:0] a, logic [47:0] cy,
                           logic [7:0] h, logic [5:0] s);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1; cmd <= c; block_address <= a; cylinder <= cy; head <= h; sector <= s;
    do @(posedge clk); while (in_stall);
    sb.note_input(c, a, cy, h, s);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 0;
    while (sb.pending.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [47:0] rnd48();
    logic [47:0] v;
    v = 48'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: v = v & 48'h3fffff;
      1: v = v & 48'hfffffff;
      2: v = v >> $urandom_range(0, 47);
      default: ;
    endcase
    return v;
  endfunction

  task automatic random_word();
    logic [47:0] cy;
    logic [7:0] h;
    logic [5:0] s;
    cy = rnd48();
    if ($urandom_range(0, 3) != 0) cy = cy >> $urandom_range(10, 47);
    h = 8'($urandom);
    if (sb.hpc != 0 && $urandom_range(0, 4) != 0) h = 8'($urandom_range(0, sb.hpc - 1));
    s = 6'($urandom);
    if (sb.spt != 0 && $urandom_range(0, 4) != 0) s = 6'($urandom_range(1, sb.spt));
    send_word(1'($urandom), rnd48(), cy, h, s);
  endtask

  initial begin
    logic [7:0] hpcs[6];
    logic [5:0] spts[6];
    logic [1:0] modes[6];
    sb = new();
    calm = 0;
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid = 0; cmd = 0; block_address = 0; cylinder = 0; head = 0; sector = 0;
    repeat (7) @(posedge clk);
    rst <= 0;

    // directed: reset geometry, edges of every field
    send_word(0, 0, 0, 0, 0);
    send_word(0, 48'hffffffffffff, 0, 0, 0);
    send_word(0, 48'hfffffffffffe, 0, 0, 0);
    send_word(0, 48'd1007, 0, 0, 0);
    send_word(1, 0, 0, 0, 1);
    send_word(1, 0, 0, 0, 0);
    send_word(1, 0, 0, 8'd16, 1);
    send_word(1, 0, 0, 8'hff, 6'h3f);
    send_word(1, 48'hffffffffffff, 0, 8'd15, 6'h3f);
    send_word(1, 48'd100, 48'd5, 8'd3, 6'd63);
    drain();
    reg_write(lcc_pkg::REG_MODE, 0);
    send_word(0, 48'h3fffff, 0, 0, 0);
    send_word(0, 48'h400000, 0, 0, 0);
    send_word(1, 0, 48'd4161, 8'd0, 6'd1);
    send_word(1, 0, 48'd4161, 8'd1, 6'd1);
    drain();
    reg_write(lcc_pkg::REG_MODE, 3);
    reg_write(lcc_pkg::REG_HPC, 0);
    send_word(0, 5, 0, 0, 0);
    send_word(1, 0, 1, 0, 1);
    drain();
    reg_write(lcc_pkg::REG_HPC, 255);
    reg_write(lcc_pkg::REG_SPT, 0);
    send_word(0, 5, 0, 0, 0);
    send_word(1, 0, 1, 0, 1);
    drain();
    reg_write(lcc_pkg::REG_SPT, 63);
    send_word(1, 48'hffffffffffff, 0, 8'd254, 6'd63);
    send_word(0, 48'hffffffffffff, 0, 0, 0);
    send_word(1, 48'd3, 0, 8'd254, 6'd1);
    send_word(1, 0, 48'hffffffffffff, 8'd254, 6'd63);
    drain();

    // random phases across several geometries
    hpcs = '{8'd1, 8'd255, 8'd16, 8'd7, 8'd0, 8'd200};
    spts = '{6'd1, 6'd63, 6'd63, 6'd17, 6'd5, 6'd0};
    modes = '{2'd0, 2'd2, 2'd1, 2'd3, 2'd1, 2'd0};
    for (int p = 0; p < 10; p++) begin
      if (p < 6) begin
        reg_write(lcc_pkg::REG_HPC, {24'd0, hpcs[p]});
        reg_write(lcc_pkg::REG_SPT, {26'd0, spts[p]});
        reg_write(lcc_pkg::REG_MODE, {30'd0, modes[p]});
      end else begin
        reg_write(lcc_pkg::REG_HPC, $urandom_range(1, 255));
        reg_write(lcc_pkg::REG_SPT, $urandom_range(1, 63));
        reg_write(lcc_pkg::REG_MODE, $urandom_range(0, 3));
      end
      if (p == 9) calm = 1;
      for (int i = 0; i < 200; i++) begin
        random_word();
        // sender pauses until the pipe is empty
        if (p == 2 && i == 100) begin
          in_valid <= 0;
          while (sb.pending.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/lcc_pkg.sv
rtl/lcc_cfg.sv
rtl/lcc_entry.sv
rtl/lcc_stage.sv
rtl/lba_chs_converter.sv
tb/sv/testbench.sv
